>>> rtl/dihed_pkg.sv
// Package with constants, types and tables for the dihedral angle pipeline.
`default_nettype none
package dihed_pkg;

  // Angle output format, CORDIC and square root lengths, and pipeline depth.
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int ISQRT_STEPS     = 32;
  localparam int FRONT_STAGES    = 12;
  localparam int LATENCY         = FRONT_STAGES + ISQRT_STEPS + CORDIC_STEPS + 1;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [33:0] ROUND_HALF = 34'(1) << (29 - ANGLE_FRAC_BITS);

  // Flags that travel along with an item.
  typedef struct packed {
    logic deg;
    logic tneg;
  } side_t;

  // Table of atan(2^-i) in Q30.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Right shift that brings a magnitude of the given bit length below 2^30.
  function automatic logic [6:0] reduce_shift(input logic [66:0] v);
    logic [6:0] bl;
    bl = 7'd0;
    for (int k = 0; k < 67; k++) begin
      if (v[k]) bl = 7'(k + 1);
    end
    return (bl > 7'd30) ? bl - 7'd30 : 7'd0;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dihedral_angle_four_points_core.sv
// Dihedral angle of four points: exact cross products, reduction, isqrt and CORDIC.
// Pipeline: a chain of register stages, the last of which is the output
// register that holds torsion and degenerate.
// Throughput: one set of four points per cycle; the whole pipeline advances
// together and holds in place while the output register waits for out_ready.
// Reset: rst clears all valid bits and holds in_ready low; data registers are not reset.
// The longest part is the 32-stage integer square root followed by 24 CORDIC stages.
`default_nettype none
module dihedral_angle_four_points_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] p1_x,
  input  wire logic signed [31:0] p1_y,
  input  wire logic signed [31:0] p1_z,
  input  wire logic signed [31:0] p2_x,
  input  wire logic signed [31:0] p2_y,
  input  wire logic signed [31:0] p2_z,
  input  wire logic signed [31:0] p3_x,
  input  wire logic signed [31:0] p3_y,
  input  wire logic signed [31:0] p3_z,
  input  wire logic signed [31:0] p4_x,
  input  wire logic signed [31:0] p4_y,
  input  wire logic signed [31:0] p4_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [18:0]      torsion,
  output logic                    degenerate
);

  localparam int L = dihed_pkg::LATENCY;
  localparam int NI = dihed_pkg::ISQRT_STEPS;
  localparam int NC = dihed_pkg::CORDIC_STEPS;

  logic en;
  logic [L-1:0] vp;

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !vp[L-1] || out_ready;
  assign in_ready = en && !rst;
  assign out_valid = vp[L-1];

  // Valid bits shift along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[L-2:0], in_valid};
    end
  end

  // Stage 1: point differences.
  logic signed [32:0] s1_v12 [3];
  logic signed [32:0] s1_ax [3];
  logic signed [32:0] s1_v43 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v12[0] <= 33'(p1_x) - 33'(p2_x);
      s1_v12[1] <= 33'(p1_y) - 33'(p2_y);
      s1_v12[2] <= 33'(p1_z) - 33'(p2_z);
      s1_ax[0]  <= 33'(p2_x) - 33'(p3_x);
      s1_ax[1]  <= 33'(p2_y) - 33'(p3_y);
      s1_ax[2]  <= 33'(p2_z) - 33'(p3_z);
      s1_v43[0] <= 33'(p4_x) - 33'(p3_x);
      s1_v43[1] <= 33'(p4_y) - 33'(p3_y);
      s1_v43[2] <= 33'(p4_z) - 33'(p3_z);
    end
  end

  // Stage 2: partial products of both cross products.
  logic signed [65:0] s2_pt [6];
  logic signed [65:0] s2_pu [6];
  logic signed [32:0] s2_v12 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s2_pt[0] <= s1_v12[1] * s1_ax[2];
      s2_pt[1] <= s1_v12[2] * s1_ax[1];
      s2_pt[2] <= s1_v12[2] * s1_ax[0];
      s2_pt[3] <= s1_v12[0] * s1_ax[2];
      s2_pt[4] <= s1_v12[0] * s1_ax[1];
      s2_pt[5] <= s1_v12[1] * s1_ax[0];
      s2_pu[0] <= s1_v43[1] * s1_ax[2];
      s2_pu[1] <= s1_v43[2] * s1_ax[1];
      s2_pu[2] <= s1_v43[2] * s1_ax[0];
      s2_pu[3] <= s1_v43[0] * s1_ax[2];
      s2_pu[4] <= s1_v43[0] * s1_ax[1];
      s2_pu[5] <= s1_v43[1] * s1_ax[0];
      s2_v12   <= s1_v12;
    end
  end

  // Stage 3: exact cross product components.
  logic signed [66:0] s3_vt [3];
  logic signed [66:0] s3_vu [3];
  logic signed [32:0] s3_v12 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_vt[k] <= 67'(s2_pt[2*k]) - 67'(s2_pt[2*k+1]);
        s3_vu[k] <= 67'(s2_pu[2*k]) - 67'(s2_pu[2*k+1]);
      end
      s3_v12 <= s2_v12;
    end
  end

  // Stage 4: split products for v12 . vu, magnitudes and the degenerate test.
  logic signed [67:0] s4_tlo [3];
  logic signed [65:0] s4_thi [3];
  logic [66:0] s4_mt [3];
  logic [66:0] s4_mu [3];
  logic [2:0]  s4_st;
  logic [2:0]  s4_su;
  logic        s4_deg;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_tlo[k] <= $signed({1'b0, s3_vu[k][33:0]}) * s3_v12[k];
        s4_thi[k] <= $signed(s3_vu[k][66:34]) * s3_v12[k];
        s4_mt[k]  <= s3_vt[k][66] ? 67'(-s3_vt[k]) : 67'(s3_vt[k]);
        s4_mu[k]  <= s3_vu[k][66] ? 67'(-s3_vu[k]) : 67'(s3_vu[k]);
        s4_st[k]  <= s3_vt[k][66];
        s4_su[k]  <= s3_vu[k][66];
      end
      s4_deg <= ((s3_vt[0] | s3_vt[1] | s3_vt[2]) == '0) ||
                ((s3_vu[0] | s3_vu[1] | s3_vu[2]) == '0);
    end
  end

  // Stage 5: recombine the split products and find the reduction shifts.
  logic signed [100:0] s5_tk [3];
  logic [66:0] s5_mt [3];
  logic [66:0] s5_mu [3];
  logic [2:0]  s5_st;
  logic [2:0]  s5_su;
  logic [6:0]  s5_sht;
  logic [6:0]  s5_shu;
  logic        s5_deg;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_tk[k] <= $signed({s4_thi[k][65], s4_thi[k], 34'b0}) +
                    $signed({{33{s4_tlo[k][67]}}, s4_tlo[k]});
      end
      s5_mt  <= s4_mt;
      s5_mu  <= s4_mu;
      s5_st  <= s4_st;
      s5_su  <= s4_su;
      s5_sht <= dihed_pkg::reduce_shift(s4_mt[0] | s4_mt[1] | s4_mt[2]);
      s5_shu <= dihed_pkg::reduce_shift(s4_mu[0] | s4_mu[1] | s4_mu[2]);
      s5_deg <= s4_deg;
    end
  end

  // Stage 6: sign of v12 . vu and the reduced copies of vt and vu.
  logic signed [30:0] s6_a [3];
  logic signed [30:0] s6_b [3];
  dihed_pkg::side_t   s6_sd;
  logic signed [101:0] s6_tsum;
  logic [29:0] s6_ra [3];
  logic [29:0] s6_rb [3];
  always_comb begin
    s6_tsum = 102'(s5_tk[0]) + 102'(s5_tk[1]) + 102'(s5_tk[2]);
    for (int k = 0; k < 3; k++) begin
      s6_ra[k] = 30'(s5_mt[k] >> s5_sht);
      s6_rb[k] = 30'(s5_mu[k] >> s5_shu);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_a[k] <= s5_st[k] ? -$signed({1'b0, s6_ra[k]}) : $signed({1'b0, s6_ra[k]});
        s6_b[k] <= s5_su[k] ? -$signed({1'b0, s6_rb[k]}) : $signed({1'b0, s6_rb[k]});
      end
      s6_sd.deg  <= s5_deg;
      s6_sd.tneg <= s6_tsum[101];
    end
  end

  // Stage 7: products for the reduced cross and dot products.
  logic signed [61:0] s7_p [9];
  dihed_pkg::side_t   s7_sd;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_p[0] <= s6_a[1] * s6_b[2];
      s7_p[1] <= s6_a[2] * s6_b[1];
      s7_p[2] <= s6_a[2] * s6_b[0];
      s7_p[3] <= s6_a[0] * s6_b[2];
      s7_p[4] <= s6_a[0] * s6_b[1];
      s7_p[5] <= s6_a[1] * s6_b[0];
      s7_p[6] <= s6_a[0] * s6_b[0];
      s7_p[7] <= s6_a[1] * s6_b[1];
      s7_p[8] <= s6_a[2] * s6_b[2];
      s7_sd   <= s6_sd;
    end
  end

  // Stage 8: cross product c and dot product d.
  logic signed [63:0] s8_c [4];
  dihed_pkg::side_t   s8_sd;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_c[0] <= 64'(s7_p[0]) - 64'(s7_p[1]);
      s8_c[1] <= 64'(s7_p[2]) - 64'(s7_p[3]);
      s8_c[2] <= 64'(s7_p[4]) - 64'(s7_p[5]);
      s8_c[3] <= 64'(s7_p[6]) + 64'(s7_p[7]) + 64'(s7_p[8]);
      s8_sd   <= s7_sd;
    end
  end

  // Stage 9: magnitudes and the shared reduction shift.
  logic [63:0] s9_m [4];
  logic [3:0]  s9_s;
  logic [6:0]  s9_sh;
  dihed_pkg::side_t s9_sd;
  logic [63:0] s9_mag [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s9_mag[k] = s8_c[k][63] ? 64'(-s8_c[k]) : 64'(s8_c[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s9_m[k] <= s9_mag[k];
        s9_s[k] <= s8_c[k][63];
      end
      s9_sh <= dihed_pkg::reduce_shift({3'b0, s9_mag[0] | s9_mag[1] | s9_mag[2] | s9_mag[3]});
      s9_sd <= s8_sd;
    end
  end

  // Stage 10: reduced c and d.
  logic signed [30:0] s10_c [4];
  dihed_pkg::side_t   s10_sd;
  logic [29:0] s10_r [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s10_r[k] = 30'(s9_m[k] >> s9_sh);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s10_c[k] <= s9_s[k] ? -$signed({1'b0, s10_r[k]}) : $signed({1'b0, s10_r[k]});
      end
      s10_sd <= s9_sd;
    end
  end

  // Stage 11: squares of the cross product components.
  logic signed [61:0] s11_sq [3];
  logic signed [30:0] s11_d;
  dihed_pkg::side_t   s11_sd;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s11_sq[k] <= s10_c[k] * s10_c[k];
      end
      s11_d  <= s10_c[3];
      s11_sd <= s10_sd;
    end
  end

  // Stage 12: squared length of c.
  logic [63:0] s12_q;
  logic signed [30:0] s12_d;
  dihed_pkg::side_t   s12_sd;
  always_ff @(posedge clk) begin
    if (en) begin
      s12_q  <= 64'(s11_sq[0][59:0]) + 64'(s11_sq[1][59:0]) + 64'(s11_sq[2][59:0]);
      s12_d  <= s11_d;
      s12_sd <= s11_sd;
    end
  end

  // Integer square root, one result bit per stage.
  logic [63:0] iq_q [NI];
  logic [63:0] iq_r [NI];
  logic signed [30:0] iq_d [NI];
  dihed_pkg::side_t   iq_sd [NI];
  for (genvar j = 0; j < NI; j++) begin : g_isqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] q_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic signed [30:0] d_in;
    dihed_pkg::side_t   sd_in;
    if (j == 0) begin : g_first
      assign q_in  = s12_q;
      assign r_in  = '0;
      assign d_in  = s12_d;
      assign sd_in = s12_sd;
    end else begin : g_next
      assign q_in  = iq_q[j-1];
      assign r_in  = iq_r[j-1];
      assign d_in  = iq_d[j-1];
      assign sd_in = iq_sd[j-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (q_in >= trial) begin
          iq_q[j] <= q_in - trial;
          iq_r[j] <= (r_in >> 1) + BIT;
        end else begin
          iq_q[j] <= q_in;
          iq_r[j] <= r_in >> 1;
        end
        iq_d[j]  <= d_in;
        iq_sd[j] <= sd_in;
      end
    end
  end

  // CORDIC start point: fold a negative d into the right half plane.
  logic signed [35:0] cx0;
  logic signed [35:0] cy0;
  logic signed [33:0] cz0;
  always_comb begin
    if (iq_d[NI-1] < 0) begin
      cx0 = $signed({4'b0, iq_r[NI-1][31:0]});
      cy0 = -36'(iq_d[NI-1]);
      cz0 = dihed_pkg::HALF_PI_Q30;
    end else begin
      cx0 = 36'(iq_d[NI-1]);
      cy0 = $signed({4'b0, iq_r[NI-1][31:0]});
      cz0 = '0;
    end
  end

  // CORDIC vectoring, one rotation per stage.
  logic signed [35:0] cr_x [NC];
  logic signed [35:0] cr_y [NC];
  logic signed [33:0] cr_z [NC];
  dihed_pkg::side_t   cr_sd [NC];
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [33:0] ATAN = dihed_pkg::atan_q30(i);
    logic signed [35:0] x_in;
    logic signed [35:0] y_in;
    logic signed [33:0] z_in;
    dihed_pkg::side_t   sd_in;
    if (i == 0) begin : g_first
      assign x_in  = cx0;
      assign y_in  = cy0;
      assign z_in  = cz0;
      assign sd_in = iq_sd[NI-1];
    end else begin : g_next
      assign x_in  = cr_x[i-1];
      assign y_in  = cr_y[i-1];
      assign z_in  = cr_z[i-1];
      assign sd_in = cr_sd[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in > 0) begin
          cr_x[i] <= x_in + (y_in >>> i);
          cr_y[i] <= y_in - (x_in >>> i);
          cr_z[i] <= z_in + ATAN;
        end else begin
          cr_x[i] <= x_in - (y_in >>> i);
          cr_y[i] <= y_in + (x_in >>> i);
          cr_z[i] <= z_in - ATAN;
        end
        cr_sd[i] <= sd_in;
      end
    end
  end

  // Output stage: clamp to [0, pi], round, apply the sign rule; degenerate sets give zero.
  logic signed [33:0] zc;
  logic [33:0] ang;
  logic [33:0] sang;
  always_comb begin
    if (cr_z[NC-1] < 0) begin
      zc = '0;
    end else if (cr_z[NC-1] > dihed_pkg::PI_Q30) begin
      zc = dihed_pkg::PI_Q30;
    end else begin
      zc = cr_z[NC-1];
    end
    ang  = (34'(zc) + dihed_pkg::ROUND_HALF) >> (30 - dihed_pkg::ANGLE_FRAC_BITS);
    sang = cr_sd[NC-1].tneg ? (34'd0 - ang) : ang;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (cr_sd[NC-1].deg) begin
        torsion    <= '0;
        degenerate <= 1'b1;
      end else begin
        torsion    <= $signed(sang[18:0]);
        degenerate <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the dihedral angle pipeline, with its own angle predictor.
`default_nettype none
module tb_top;

  typedef struct packed {
    logic signed [18:0] torsion;
    logic               degenerate;
  } angle_t;

  typedef struct {
    logic signed [31:0] c[12];
    bit                 typed;
    angle_t             want;
  } row_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_RANDOM     = 1030;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] pt[12];
  logic signed [18:0] torsion;
  logic               degenerate;

  angle_t angle_fifo[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 0;

  dihedral_angle_four_points_core DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .p1_x(pt[0]), .p1_y(pt[1]), .p1_z(pt[2]),
    .p2_x(pt[3]), .p2_y(pt[4]), .p2_z(pt[5]),
    .p3_x(pt[6]), .p3_y(pt[7]), .p3_z(pt[8]),
    .p4_x(pt[9]), .p4_y(pt[10]), .p4_z(pt[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .torsion(torsion), .degenerate(degenerate)
  );

  // Arctangent of 2^-i in Q30.
  localparam longint ATAN_TAB[32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
    8, 4, 2, 1, 0};

  function automatic int bit_length(input logic [127:0] v);
    int n;
    n = 0;
    for (int k = 0; k < 128; k++) if (v[k]) n = k + 1;
    return n;
  endfunction

  // Scales three exact components so the largest magnitude is below 2^30.
  function automatic void shrink3(input logic signed [127:0] v[3], output longint o[3]);
    logic [127:0] m[3];
    int bl, s;
    bl = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = v[k] < 0 ? -v[k] : v[k];
      if (bit_length(m[k]) > bl) bl = bit_length(m[k]);
    end
    s = bl > 30 ? bl - 30 : 0;
    for (int k = 0; k < 3; k++) begin
      o[k] = longint'((m[k] >> s) & 128'h3FFF_FFFF);
      if (v[k] < 0) o[k] = -o[k];
    end
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned q);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected torsion angle of one set of four points.
  function automatic angle_t predict_torsion(input logic signed [31:0] c[12]);
    logic signed [127:0] v12[3], ax[3], v43[3], vt[3], vu[3], sdot;
    longint a[3], b[3], w[4], x, y, z, dx, dy;
    longint unsigned mx, q, ang;
    int s;
    angle_t res;
    for (int k = 0; k < 3; k++) begin
      v12[k] = 128'(c[k]) - 128'(c[3+k]);
      ax[k]  = 128'(c[3+k]) - 128'(c[6+k]);
      v43[k] = 128'(c[9+k]) - 128'(c[6+k]);
    end
    vt[0] = v12[1]*ax[2] - v12[2]*ax[1];
    vt[1] = v12[2]*ax[0] - v12[0]*ax[2];
    vt[2] = v12[0]*ax[1] - v12[1]*ax[0];
    vu[0] = v43[1]*ax[2] - v43[2]*ax[1];
    vu[1] = v43[2]*ax[0] - v43[0]*ax[2];
    vu[2] = v43[0]*ax[1] - v43[1]*ax[0];
    res.torsion = '0;
    res.degenerate = 1'b1;
    if ((vt[0] == 0 && vt[1] == 0 && vt[2] == 0) || (vu[0] == 0 && vu[1] == 0 && vu[2] == 0))
      return res;
    sdot = vu[0]*v12[0] + vu[1]*v12[1] + vu[2]*v12[2];
    shrink3(vt, a);
    shrink3(vu, b);
    w[0] = a[1]*b[2] - a[2]*b[1];
    w[1] = a[2]*b[0] - a[0]*b[2];
    w[2] = a[0]*b[1] - a[1]*b[0];
    w[3] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    mx = 0;
    for (int k = 0; k < 4; k++) if ((w[k] < 0 ? -w[k] : w[k]) > mx) mx = w[k] < 0 ? -w[k] : w[k];
    s = bit_length(128'(mx)) > 30 ? bit_length(128'(mx)) - 30 : 0;
    for (int k = 0; k < 4; k++) w[k] = w[k] < 0 ? -((-w[k]) >>> s) : (w[k] >>> s);
    q = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
    // CORDIC vectoring of (dot, |cross|), folded into the right half-plane.
    x = w[3];
    y = longint'(floor_sqrt(q));
    z = 0;
    if (x < 0) begin
      dx = x;
      x = y;
      y = -dx;
      z = dihed_pkg::HALF_PI_Q30;
    end
    for (int i = 0; i < dihed_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > dihed_pkg::PI_Q30) z = dihed_pkg::PI_Q30;
    ang = (longint'(z) + (64'd1 << (29 - dihed_pkg::ANGLE_FRAC_BITS)))
          >> (30 - dihed_pkg::ANGLE_FRAC_BITS);
    res.torsion = sdot < 0 ? 19'(-ang) : 19'(ang);
    res.degenerate = 1'b0;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $signed($urandom);
      1: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom) >>> $urandom_range(12, 24);
    endcase
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    angle_t want;
    if (!rst && out_valid && out_ready) begin
      if (angle_fifo.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = angle_fifo.pop_front();
        if (torsion !== want.torsion) begin
          $error("torsion expected %0d actual %0d", want.torsion, torsion);
          errors++;
        end
        if (degenerate !== want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, degenerate);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in random patterns: always ready, random, rarely ready or toggling.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          2: out_ready = ($urandom_range(0, 7) == 0);
          default: out_ready = ~out_ready;
        endcase
      end
    end
  end

  // Sends one set of points and records its expected result at the transfer.
  task automatic send_points(input logic signed [31:0] c[12], input angle_t want);
    @(negedge clk);
    pt = c;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    angle_fifo.push_back(want);
  endtask

  initial begin
    row_t   rows[$];
    row_t   r;
    logic signed [31:0] c[12];
    int     burst, gap;
    angle_t zero_ang, deg_ang;

    in_valid = 1'b0;
    foreach (pt[k]) pt[k] = '0;
    zero_ang = '{torsion: '0, degenerate: 1'b0};
    deg_ang  = '{torsion: '0, degenerate: 1'b1};

    // Directed rows: degenerate shapes, cis/trans, right angles and extremes.
    r.typed = 1'b1; r.want = deg_ang;
    r.c = '{default: 0};                                    rows.push_back(r);
    r.c = '{default: 32'sh7FFF_FFFF};                       rows.push_back(r);
    r.c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            1, 2, 3};                                       rows.push_back(r);
    r.c = '{3, 0, 0, 2, 0, 0, 1, 0, 0, 0, 5, 7};            rows.push_back(r);
    // Tiny cis shape: coarse CORDIC steps leave a small residual angle.
    r.typed = 1'b0; r.want = zero_ang;
    r.c = '{1, 1, 0, 0, 1, 0, 0, 0, 0, 7, 0, 0};            rows.push_back(r);
    r.typed = 1'b1; r.want = zero_ang;
    r.c = '{65536, 65536, 0, 0, 65536, 0, 0, 0, 0, 65536, 0, 0};   rows.push_back(r);
    r.typed = 1'b0; r.want = zero_ang;
    r.c = '{-5, 9, 0, 0, 9, 0, 0, 0, 0, -3, 0, 0};          rows.push_back(r);
    r.c = '{65536, 65536, 0, 0, 65536, 0, 0, 0, 0, -65536, 0, 0};  rows.push_back(r);
    r.c = '{1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1};            rows.push_back(r);
    r.c = '{1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, -1};           rows.push_back(r);
    r.c = '{1, 1, 0, 0, 1, 0, 0, 0, 0, -1, 0, 1};           rows.push_back(r);
    r.c = '{1, 1, 0, 0, 1, 0, 0, 0, 0, -1, 0, -1};          rows.push_back(r);
    r.c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF, 0,
            0, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF}; rows.push_back(r);
    r.c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000}; rows.push_back(r);
    r.c = '{32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 0, 32'sh8000_0000, 1, 1}; rows.push_back(r);
    r.c = '{-1, -1, -1, 0, 0, 0, 1, 1, 0, 2, 1, 1};         rows.push_back(r);
    r.c = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 11};        rows.push_back(r);

    wait (!rst);
    foreach (rows[i]) send_points(rows[i].c, rows[i].typed ? rows[i].want
                                                            : predict_torsion(rows[i].c));

    // Random sets in bursts; some are deliberately collinear or coincident.
    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst--;
      foreach (c[k]) c[k] = rand_coord();
      case ($urandom_range(0, 15))
        0: for (int k = 0; k < 3; k++) c[6+k] = c[3+k];
        1: for (int k = 0; k < 3; k++) c[k] = c[3+k] + (c[3+k] - c[6+k]);
        2: for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + (c[6+k] - c[3+k]) * 2;
        3: for (int k = 0; k < 3; k++) c[9+k] = c[k] - c[3+k] + c[6+k];
        default: ;
      endcase
      send_points(c, predict_torsion(c));
    end
    @(negedge clk);
    in_valid = 1'b0;

    wait (angle_fifo.size() == 0);
    repeat (dihed_pkg::LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/dihed_pkg.sv
rtl/dihedral_angle_four_points_core.sv
tb/tb_top.sv
